// ===== src/hsacc_pkg.sv =====
// Shared types, constants and codes for the network model Hessian accumulator.
package hsacc_pkg;

	localparam int COORD_W  = 32;
	localparam int CUTOFF_W = 32;
	localparam int ENTRY_W  = 40;
	localparam int DIFF_W   = 33;	// coordinate difference
	localparam int SUMSQ_W  = 66;	// sum of three squares
	localparam int ROOT_W   = 33;	// distance
	localparam int DIVN_W   = 50;	// dividend and quotient magnitude
	localparam int REM_W    = 36;
	localparam int SRC_W    = 66;
	localparam int MUL_W    = 34;
	localparam int PROD_W   = 2 * MUL_W;
	localparam int U_W      = 18;	// unit vector component, |u| <= 1.0
	localparam int UUP_W    = 36;
	localparam int S_SPLIT  = 20;	// low part width of the strain for split products
	localparam int HP_W     = 58;	// (1 - s) * uu before scaling
	localparam int H_W      = 43;
	localparam int ACC_W    = 44;
	localparam int CNT_W    = 6;
	localparam int SQRT_STEPS = 33;
	localparam int DIV_STEPS  = 50;

	localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 32'd98304;
	localparam logic signed [ENTRY_W-1:0] ENTRY_MAX = 40'sh7F_FFFF_FFFF;
	localparam logic signed [ENTRY_W-1:0] ENTRY_MIN = 40'sh80_0000_0000;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_PAIR  = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SKIP  = 2'd1,
		ST_RANGE = 2'd2,
		ST_SAT   = 2'd3
	} status_t;

	typedef struct packed {
		op_t                        op;
		logic [5:0]                 residue_a;
		logic [5:0]                 residue_b;
		logic signed [COORD_W-1:0]  pos_x;
		logic signed [COORD_W-1:0]  pos_y;
		logic signed [COORD_W-1:0]  pos_z;
		logic [CUTOFF_W-1:0]        ref_distance;
		logic [7:0]                 row;
		logic [7:0]                 col;
	} in_item_t;

	typedef struct packed {
		logic signed [ENTRY_W-1:0]  entry_value;
		status_t                    status;
	} out_item_t;

	typedef struct packed {
		logic start;
		logic sqrt_mode;
	} iter_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVN_W-1:0] result;
	} iter_rsp_t;

	typedef struct packed {
		logic rd;
		logic wr;
		logic clr;
	} hmem_req_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CRD_A,
		S_CRD_B,
		S_DIFF,
		S_SQ_MUL,
		S_SQ_ACC,
		S_SQRT,
		S_SQRT_WAIT,
		S_DIV,
		S_DIV_WAIT,
		S_UU_MUL,
		S_UU_TRUNC,
		S_H_LO,
		S_H_HI,
		S_H_COMB,
		S_ACC_RD,
		S_ACC_WR,
		S_RD_MEM,
		S_RD_DATA,
		S_RESP
	} seq_state_t;

endpackage

// ===== src/hsacc_iter.sv =====
// Shared shift-subtract unit: integer square root or unsigned division, one bit a cycle.
module hsacc_iter import hsacc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  iter_req_t         req,
	input  logic [SRC_W-1:0]  operand,	// radicand, or dividend left aligned
	input  logic [ROOT_W-1:0] divisor,
	output iter_rsp_t         rsp
);

	logic              busy_q;
	logic              done_q;
	logic              sqrt_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [REM_W-1:0]  rem_q;
	logic [DIVN_W-1:0] acc_q;
	logic [SRC_W-1:0]  src_q;
	logic [ROOT_W-1:0] div_q;

	logic [REM_W-1:0]  shifted;
	logic [REM_W-1:0]  trial;
	logic [REM_W:0]    sub;
	logic              take;

	// sqrt brings down two bits and tries 4*root+1; divide brings down one bit
	assign shifted = sqrt_q ? {rem_q[REM_W-3:0], src_q[SRC_W-1 -: 2]}
	                        : {rem_q[REM_W-2:0], src_q[SRC_W-1]};
	assign trial   = sqrt_q ? REM_W'({acc_q[ROOT_W-1:0], 2'b01}) : REM_W'(div_q);
	assign sub     = {1'b0, shifted} - {1'b0, trial};
	assign take    = !sub[REM_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.sqrt_mode ? CNT_W'(SQRT_STEPS - 1) : CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			sqrt_q <= req.sqrt_mode;
			rem_q  <= '0;
			acc_q  <= '0;
			src_q  <= operand;
			div_q  <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? sub[REM_W-1:0] : shifted;
			acc_q <= {acc_q[DIVN_W-2:0], take};
			src_q <= sqrt_q ? {src_q[SRC_W-3:0], 2'b00} : {src_q[SRC_W-2:0], 1'b0};
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = acc_q;

endmodule

// ===== src/hsacc_hmem.sv =====
// Hessian entry memory, single port, registered read, with a zeroing sweep.
module hsacc_hmem import hsacc_pkg::*; #(
	parameter int DEPTH = 36864
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  hmem_req_t                  req,
	input  logic [$clog2(DEPTH)-1:0]   addr,
	input  logic signed [ENTRY_W-1:0]  wdata,
	output logic signed [ENTRY_W-1:0]  rdata,
	output logic                       busy
);

	localparam int AW = $clog2(DEPTH);

	logic signed [ENTRY_W-1:0] mem_q [DEPTH];
	logic signed [ENTRY_W-1:0] rdata_q;
	logic [AW-1:0]             clr_addr_q;
	logic                      busy_q;

	// the sweep runs out of reset and again on each clear request that arrives while no sweep runs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			if (clr_addr_q == AW'(DEPTH - 1))
				busy_q <= 1'b0;
			clr_addr_q <= clr_addr_q + 1'b1;
		end else if (req.clr) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q)
			mem_q[clr_addr_q] <= '0;
		else if (req.wr)
			mem_q[addr] <= wdata;
		if (req.rd)
			rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;
	assign busy  = busy_q;

endmodule

// ===== src/network_model_hessian_accumulator.sv =====
// Top level: sequencer, coordinate memory and multiplier of the Hessian accumulator.
//
//  channel   signals                          direction  carries
//  in        in_valid / in_ready / in_data    into       in_item_t, one command
//  out       out_valid / out_ready / out_data out of     out_item_t, one per command
//  cfg       cfg_wr_en / cfg_wr_data          into       cutoff_distance
//
// Load, clear and rejected commands present their result in the cycle after their transfer;
// a read passes through S_RD_MEM and S_RD_DATA first. An accepted pair computes the squares,
// the square root and four divisions on the shared shift-subtract unit, then nine updates.
// After reset and after each clear the Hessian memory is swept to zero, one entry a
// cycle over all (3*MAX_RESIDUES)^2 entries, 36864 by default, with in_ready low.
// One command at a time; in_ready stays low until the previous result is transferred.
module network_model_hessian_accumulator import hsacc_pkg::*; #(
	parameter int MAX_RESIDUES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  in_item_t            in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output out_item_t           out_data,
	input  logic                cfg_wr_en,
	input  logic [CUTOFF_W-1:0] cfg_wr_data
);

	localparam int DOF    = 3 * MAX_RESIDUES;
	localparam int CW     = $clog2(MAX_RESIDUES);
	localparam int DW     = $clog2(DOF);
	localparam int HDEPTH = DOF * DOF;
	localparam int AW     = $clog2(HDEPTH);

	seq_state_t state_q, state_d;

	in_item_t            item_q;
	logic [CUTOFF_W-1:0] cutoff_q;
	logic [1:0]          k_q, p_q, q_q, div_idx_q;
	logic                sat_q;

	logic [3*COORD_W-1:0] coord_mem [MAX_RESIDUES];
	logic [3*COORD_W-1:0] coord_rd_q;
	logic [3*COORD_W-1:0] pa_q;
	logic [CW-1:0]        coord_rd_idx;

	logic signed [DIFF_W-1:0] diff_q [3];
	logic [SUMSQ_W-1:0]       sumsq_q;
	logic [ROOT_W-1:0]        d_q;
	logic signed [ENTRY_W-1:0] s_q;
	logic signed [U_W-1:0]    u_q [3];
	logic signed [U_W-1:0]    uu_q;
	logic signed [HP_W-1:0]   tlo_q;
	logic signed [H_W-1:0]    h_q;
	logic [AW-1:0]            addr_q;
	logic                     div_neg_q;
	logic signed [ENTRY_W-1:0] res_value_q;
	status_t                  res_status_q;

	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_s1;

	logic                     in_fire;
	logic                     in_a_ok, in_b_ok, in_rc_ok;
	status_t                  acc_status;
	seq_state_t               acc_next;

	logic [CW-1:0]            a_idx, b_idx, rp_sel, cp_sel;
	logic [DW-1:0]            row_dof, col_dof;
	logic [AW-1:0]            acc_addr, rd_addr;

	hmem_req_t                 hreq;
	logic [AW-1:0]             haddr;
	logic signed [ENTRY_W-1:0] hwdata, hrdata;
	logic                      hbusy;

	iter_req_t                 ireq;
	iter_rsp_t                 irsp;
	logic [SRC_W-1:0]          i_operand;

	logic signed [DIFF_W:0]    s_num;
	logic signed [DIFF_W-1:0]  u_num;
	logic                      num_neg;
	logic [DIFF_W:0]           num_mag;

	logic signed [DIVN_W:0]    div_val;
	logic                      clamp_hi, clamp_lo;

	logic signed [UUP_W-1:0]   uu_prod, uu_adj;
	logic signed [HP_W-1:0]    hprod, hadj;
	logic signed [H_W-1:0]     h_base, h_new;

	logic signed [ACC_W-1:0]   acc_sum;
	logic signed [ENTRY_W-1:0] acc_res;
	logic                      sat_now;

	assign in_fire  = in_valid && in_ready;
	assign in_a_ok  = int'(in_data.residue_a) < MAX_RESIDUES;
	assign in_b_ok  = int'(in_data.residue_b) < MAX_RESIDUES;
	assign in_rc_ok = (int'(in_data.row) < DOF) && (int'(in_data.col) < DOF);

	assign a_idx    = CW'(item_q.residue_a);
	assign b_idx    = CW'(item_q.residue_b);
	assign rp_sel   = k_q[1] ? b_idx : a_idx;
	assign cp_sel   = k_q[0] ? b_idx : a_idx;
	assign row_dof  = DW'(rp_sel) * DW'(3) + DW'(p_q);
	assign col_dof  = DW'(cp_sel) * DW'(3) + DW'(q_q);
	assign acc_addr = AW'(row_dof) * AW'(DOF) + AW'(col_dof);
	assign rd_addr  = AW'(item_q.row) * AW'(DOF) + AW'(item_q.col);

	assign coord_rd_idx = (state_q == S_CRD_B) ? b_idx : a_idx;

	// strain numerator d - d0, or a coordinate difference, as sign and magnitude
	assign s_num   = $signed({1'b0, d_q}) - $signed({2'b00, item_q.ref_distance});
	assign u_num   = diff_q[div_idx_q - 2'd1];
	always_comb begin
		if (div_idx_q == 2'd0) begin
			num_neg = s_num[DIFF_W];
			num_mag = num_neg ? 34'(-s_num) : 34'(s_num);
		end else begin
			num_neg = u_num[DIFF_W-1];
			num_mag = num_neg ? 34'(-(DIFF_W+1)'(u_num)) : 34'((DIFF_W+1)'(u_num));
		end
	end

	assign div_val  = div_neg_q ? -$signed({1'b0, irsp.result}) : $signed({1'b0, irsp.result});
	assign clamp_hi = div_val > (DIVN_W+1)'(ENTRY_MAX);
	assign clamp_lo = div_val < (DIVN_W+1)'(ENTRY_MIN);

	// products truncate toward zero on the way down by 2^16
	assign uu_prod = UUP_W'(prod_s1);
	assign uu_adj  = uu_prod[UUP_W-1] ? uu_prod + UUP_W'(65535) : uu_prod;
	assign hprod   = (HP_W'(uu_q) <<< 16) - ((HP_W'(prod_s1) <<< S_SPLIT) + tlo_q);
	assign hadj    = hprod[HP_W-1] ? hprod + HP_W'(65535) : hprod;
	assign h_base  = H_W'(hadj >>> 16);
	assign h_new   = h_base + ((p_q == q_q) ? H_W'(s_q) : H_W'(0));

	// diagonal sub-blocks add, off-diagonal ones subtract
	assign acc_sum = ACC_W'(hrdata) +
		((k_q == 2'd0 || k_q == 2'd3) ? ACC_W'(h_q) : -ACC_W'(h_q));
	always_comb begin
		sat_now = 1'b0;
		acc_res = ENTRY_W'(acc_sum);
		if (acc_sum > ACC_W'(ENTRY_MAX)) begin
			acc_res = ENTRY_MAX;
			sat_now = 1'b1;
		end else if (acc_sum < ACC_W'(ENTRY_MIN)) begin
			acc_res = ENTRY_MIN;
			sat_now = 1'b1;
		end
	end

	// decode of a command at its transfer
	always_comb begin
		acc_status = ST_OK;
		acc_next   = S_RESP;
		unique case (in_data.op)
			OP_LOAD: begin
				if (!in_a_ok)
					acc_status = ST_RANGE;
			end
			OP_PAIR: begin
				if (!in_a_ok || !in_b_ok)
					acc_status = ST_RANGE;
				else if (in_data.residue_a == in_data.residue_b ||
				         in_data.ref_distance >= cutoff_q)
					acc_status = ST_SKIP;
				else
					acc_next = S_CRD_A;
			end
			OP_READ: begin
				if (!in_rc_ok)
					acc_status = ST_RANGE;
				else
					acc_next = S_RD_MEM;
			end
			OP_CLEAR: begin
				acc_next = S_RESP;
			end
			default: acc_next = S_RESP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		hreq      = '0;
		haddr     = acc_addr;
		hwdata    = acc_res;
		ireq      = '0;
		i_operand = sumsq_q;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = !hbusy;
				hreq.clr = in_fire && in_data.op == OP_CLEAR;
				if (in_fire)
					state_d = acc_next;
			end
			S_CRD_A: state_d = S_CRD_B;
			S_CRD_B: state_d = S_DIFF;
			S_DIFF:  state_d = S_SQ_MUL;
			S_SQ_MUL: begin
				mul_a   = MUL_W'(diff_q[k_q]);
				mul_b   = MUL_W'(diff_q[k_q]);
				state_d = S_SQ_ACC;
			end
			S_SQ_ACC: state_d = (k_q == 2'd2) ? S_SQRT : S_SQ_MUL;
			S_SQRT: begin
				ireq.start     = 1'b1;
				ireq.sqrt_mode = 1'b1;
				state_d        = S_SQRT_WAIT;
			end
			S_SQRT_WAIT: begin
				if (irsp.done)
					state_d = (irsp.result[ROOT_W-1:0] == '0) ? S_RESP : S_DIV;
			end
			S_DIV: begin
				ireq.start = 1'b1;
				i_operand  = {num_mag, 32'b0};
				state_d    = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (irsp.done)
					state_d = (div_idx_q == 2'd3) ? S_UU_MUL : S_DIV;
			end
			S_UU_MUL: begin
				mul_a   = MUL_W'(u_q[p_q]);
				mul_b   = MUL_W'(u_q[q_q]);
				state_d = S_UU_TRUNC;
			end
			S_UU_TRUNC: state_d = S_H_LO;
			S_H_LO: begin
				mul_a   = MUL_W'($signed({1'b0, s_q[S_SPLIT-1:0]}));
				mul_b   = MUL_W'(uu_q);
				state_d = S_H_HI;
			end
			S_H_HI: begin
				mul_a   = MUL_W'($signed(s_q[ENTRY_W-1:S_SPLIT]));
				mul_b   = MUL_W'(uu_q);
				state_d = S_H_COMB;
			end
			S_H_COMB: state_d = S_ACC_RD;
			S_ACC_RD: begin
				hreq.rd = 1'b1;
				haddr   = acc_addr;
				state_d = S_ACC_WR;
			end
			S_ACC_WR: begin
				hreq.wr = 1'b1;
				haddr   = addr_q;
				if (k_q == 2'd3)
					state_d = (p_q == 2'd2 && q_q == 2'd2) ? S_RESP : S_UU_MUL;
				else
					state_d = S_ACC_RD;
			end
			S_RD_MEM: begin
				hreq.rd = 1'b1;
				haddr   = rd_addr;
				state_d = S_RD_DATA;
			end
			S_RD_DATA: state_d = S_RESP;
			S_RESP: begin
				out_valid = 1'b1;
				if (out_ready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q  <= CUTOFF_RESET;
			k_q       <= '0;
			p_q       <= '0;
			q_q       <= '0;
			div_idx_q <= '0;
			sat_q     <= 1'b0;
		end else begin
			if (cfg_wr_en)
				cutoff_q <= cfg_wr_data;
			case (state_q)
				S_IDLE: begin
					if (in_fire)
						sat_q <= 1'b0;
				end
				S_DIFF:   k_q <= '0;
				S_SQ_ACC: k_q <= k_q + 2'd1;
				S_SQRT_WAIT: begin
					if (irsp.done)
						div_idx_q <= '0;
				end
				S_DIV_WAIT: begin
					if (irsp.done) begin
						div_idx_q <= div_idx_q + 2'd1;
						if (div_idx_q == 2'd0 && (clamp_hi || clamp_lo))
							sat_q <= 1'b1;
						p_q <= '0;
						q_q <= '0;
					end
				end
				S_H_COMB: k_q <= '0;
				S_ACC_WR: begin
					k_q <= k_q + 2'd1;
					if (sat_now)
						sat_q <= 1'b1;
					if (k_q == 2'd3) begin
						if (q_q == 2'd2) begin
							q_q <= '0;
							p_q <= p_q + 2'd1;
						end else begin
							q_q <= q_q + 2'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_s1    <= PROD_W'(mul_a) * PROD_W'(mul_b);
		coord_rd_q <= coord_mem[coord_rd_idx];
		if (in_fire && in_data.op == OP_LOAD && in_a_ok)
			coord_mem[CW'(in_data.residue_a)] <= {in_data.pos_z, in_data.pos_y, in_data.pos_x};
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					item_q       <= in_data;
					res_value_q  <= '0;
					res_status_q <= acc_status;
				end
			end
			S_CRD_B: pa_q <= coord_rd_q;
			S_DIFF: begin
				diff_q[0] <= DIFF_W'($signed(pa_q[COORD_W-1:0])) -
				             DIFF_W'($signed(coord_rd_q[COORD_W-1:0]));
				diff_q[1] <= DIFF_W'($signed(pa_q[2*COORD_W-1:COORD_W])) -
				             DIFF_W'($signed(coord_rd_q[2*COORD_W-1:COORD_W]));
				diff_q[2] <= DIFF_W'($signed(pa_q[3*COORD_W-1:2*COORD_W])) -
				             DIFF_W'($signed(coord_rd_q[3*COORD_W-1:2*COORD_W]));
				sumsq_q   <= '0;
			end
			S_SQ_ACC: sumsq_q <= sumsq_q + SUMSQ_W'(prod_s1);
			S_SQRT_WAIT: begin
				if (irsp.done) begin
					d_q <= irsp.result[ROOT_W-1:0];
					if (irsp.result[ROOT_W-1:0] == '0)
						res_status_q <= ST_SKIP;
				end
			end
			S_DIV: div_neg_q <= num_neg;
			S_DIV_WAIT: begin
				if (irsp.done) begin
					if (div_idx_q == 2'd0) begin
						if (clamp_hi)
							s_q <= ENTRY_MAX;
						else if (clamp_lo)
							s_q <= ENTRY_MIN;
						else
							s_q <= ENTRY_W'(div_val);
					end else begin
						u_q[div_idx_q - 2'd1] <= U_W'(div_val);
					end
				end
			end
			S_UU_TRUNC: uu_q <= U_W'(uu_adj >>> 16);
			S_H_HI:     tlo_q <= HP_W'(prod_s1);
			S_H_COMB:   h_q <= h_new;
			S_ACC_RD:   addr_q <= acc_addr;
			S_ACC_WR: begin
				if (k_q == 2'd3 && p_q == 2'd2 && q_q == 2'd2)
					res_status_q <= (sat_q || sat_now) ? ST_SAT : ST_OK;
			end
			S_RD_DATA: res_value_q <= hrdata;
			default: ;
		endcase
	end

	assign out_data.entry_value = res_value_q;
	assign out_data.status      = res_status_q;

	hsacc_iter u_iter (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ireq),
		.operand (i_operand),
		.divisor (d_q),
		.rsp     (irsp)
	);

	hsacc_hmem #(
		.DEPTH (HDEPTH)
	) u_hmem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (hreq),
		.addr   (haddr),
		.wdata  (hwdata),
		.rdata  (hrdata),
		.busy   (hbusy)
	);

	// the shared unit only finishes while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		irsp.done |-> (state_q == S_SQRT_WAIT || state_q == S_DIV_WAIT))
		else $error("iterative unit finished outside a wait state");

	// no update may collide with the zeroing sweep
	assert property (@(posedge clk) disable iff (!arst_n)
		(hreq.wr || hreq.rd) |-> !hbusy)
		else $error("Hessian access during clearing sweep");

	// a clear transfer starts the sweep at once
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_data.op == OP_CLEAR) |=> hbusy)
		else $error("clear did not start the sweep");

	// sub-block walk stays inside the 3x3 block
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACC_WR) |-> (p_q != 2'd3 && q_q != 2'd3))
		else $error("block index out of range");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the network model Hessian accumulator.
`timescale 1ns / 100ps

module testbench;
	import hsacc_pkg::*;

	localparam int  NRES       = 64;
	localparam int  DOF        = 3 * NRES;
	localparam longint ENT_MAX = 64'sd549755813887;
	localparam longint ENT_MIN = -64'sd549755813888;
	localparam longint ONE     = 64'sd65536;
	localparam int  CYCLE_LIMIT = 2000000;
	localparam int  LONG_HOLD  = 3000;

	logic            clk;
	logic            arst_n;
	logic            in_valid;
	logic            in_ready;
	in_item_t        in_data;
	logic            out_valid;
	logic            out_ready;
	out_item_t       out_data;
	logic            cfg_wr_en;
	logic [31:0]     cfg_wr_data;

	network_model_hessian_accumulator #(.MAX_RESIDUES(NRES)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	// predictor state
	logic [31:0] cutoff_q;
	longint      crd_x[NRES];
	longint      crd_y[NRES];
	longint      crd_z[NRES];
	longint      hess[DOF*DOF];

	in_item_t    cmd_queue[$];
	out_item_t   expected_results[$];
	bit          in_fire;
	bit          quiet;
	bit          hold_req;
	int          hold_left;
	int          in_gap;
	int          out_gap;
	int          errors;
	int          cycles;
	int          n_results;
	int          n_op[4];
	int          n_sat;
	int          n_skip;
	int          n_range;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("network_model_hessian_accumulator regression: fail");
			$finish;
		end
	end

	task automatic report(string what, longint got, longint want);
		errors++;
		$display("MISMATCH %0s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
	endtask

	task automatic enq_cmd(in_item_t it);
		cmd_queue.insert(cmd_queue.size(), it);
	endtask

	function automatic bit hess_add(int r, int c, longint v);
		longint acc;
		acc = hess[r*DOF + c] + v;
		if (acc > ENT_MAX) begin
			hess[r*DOF + c] = ENT_MAX;
			return 1;
		end
		if (acc < ENT_MIN) begin
			hess[r*DOF + c] = ENT_MIN;
			return 1;
		end
		hess[r*DOF + c] = acc;
		return 0;
	endfunction

	function automatic status_t pair_update(int a, int b, longint d0);
		longint     dv[3];
		longint     u[3];
		bit [67:0]  sumsq;
		bit [67:0]  m;
		bit [67:0]  root;
		bit [67:0]  cand;
		longint     d, s, uu, h;
		bit         sat;
		int         ra, ca;
		sat = 0;
		if (a == b || d0 >= longint'(cutoff_q))
			return ST_SKIP;
		dv[0] = crd_x[a] - crd_x[b];
		dv[1] = crd_y[a] - crd_y[b];
		dv[2] = crd_z[a] - crd_z[b];
		sumsq = '0;
		for (int q = 0; q < 3; q++) begin
			m = (dv[q] < 0) ? 68'(-dv[q]) : 68'(dv[q]);
			sumsq += m * m;
		end
		root = '0;
		for (int k = 32; k >= 0; k--) begin
			cand = root | (68'd1 << k);
			if (cand * cand <= sumsq)
				root = cand;
		end
		d = longint'(root);
		if (d == 0)
			return ST_SKIP;
		s = ((d - d0) * ONE) / d;
		if (s > ENT_MAX) begin s = ENT_MAX; sat = 1; end
		if (s < ENT_MIN) begin s = ENT_MIN; sat = 1; end
		for (int q = 0; q < 3; q++)
			u[q] = (dv[q] * ONE) / d;
		for (int p = 0; p < 3; p++) begin
			for (int q = 0; q < 3; q++) begin
				uu = (u[p] * u[q]) / ONE;
				h = ((ONE - s) * uu) / ONE;
				if (p == q)
					h += s;
				for (int k = 0; k < 4; k++) begin
					ra = (k & 2) ? b : a;
					ca = (k & 1) ? b : a;
					if (hess_add(3*ra + p, 3*ca + q, (ra == ca) ? h : -h))
						sat = 1;
				end
			end
		end
		return sat ? ST_SAT : ST_OK;
	endfunction

	function automatic out_item_t hessian_step(in_item_t it);
		out_item_t r;
		longint    val;
		val = 0;
		r.status = ST_OK;
		case (it.op)
			OP_LOAD: begin
				crd_x[it.residue_a] = longint'(it.pos_x);
				crd_y[it.residue_a] = longint'(it.pos_y);
				crd_z[it.residue_a] = longint'(it.pos_z);
			end
			OP_PAIR: r.status = pair_update(int'(it.residue_a), int'(it.residue_b),
				longint'({32'd0, it.ref_distance}));
			OP_READ: begin
				if (it.row < DOF && it.col < DOF)
					val = hess[it.row*DOF + it.col];
				else
					r.status = ST_RANGE;
			end
			default: begin
				foreach (hess[i])
					hess[i] = 0;
			end
		endcase
		r.entry_value = val[39:0];
		return r;
	endfunction

	// monitor: accepted commands feed the predictor, results are checked in order
	always @(posedge clk) begin
		out_item_t want;
		in_fire = in_valid && in_ready;
		if (in_fire) begin
			expected_results.insert(expected_results.size(), hessian_step(in_data));
			n_op[in_data.op]++;
		end
		if (out_valid && out_ready) begin
			n_results++;
			if (expected_results.size() == 0) begin
				report("unexpected result", out_data.entry_value, 0);
			end else begin
				want = expected_results.pop_front();
				if (out_data.entry_value !== want.entry_value)
					report("entry_value", out_data.entry_value, want.entry_value);
				if (out_data.status !== want.status)
					report("status", out_data.status, want.status);
				if (want.status == ST_SAT) n_sat++;
				if (want.status == ST_SKIP) n_skip++;
				if (want.status == ST_RANGE) n_range++;
			end
		end
	end

	// command driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_fire) begin
				// hold until transfer
			end else if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap--;
			end else if (cmd_queue.size() > 0) begin
				in_data  <= cmd_queue.pop_front();
				in_valid <= 1'b1;
				if (!quiet && $urandom_range(0, 4) == 0)
					in_gap = $urandom_range(1, 6);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (hold_req) begin
			hold_req  = 0;
			hold_left = LONG_HOLD;
			out_ready <= 1'b0;
		end else if (out_gap > 0) begin
			out_ready <= 1'b0;
			out_gap--;
		end else begin
			out_ready <= 1'b1;
			if (!quiet && $urandom_range(0, 4) == 0)
				out_gap = $urandom_range(1, 6);
		end
	end

	function automatic in_item_t mk(op_t op, int a, int b, int x, int y, int z,
		logic [31:0] d0, int r, int c);
		in_item_t it;
		it.op = op;
		it.residue_a = 6'(a);
		it.residue_b = 6'(b);
		it.pos_x = x;
		it.pos_y = y;
		it.pos_z = z;
		it.ref_distance = d0;
		it.row = 8'(r);
		it.col = 8'(c);
		return it;
	endfunction

	function automatic int small_coord();
		return int'($urandom_range(0, 524288)) - 262144;
	endfunction

	function automatic in_item_t random_cmd();
		in_item_t     it;
		logic [191:0] raw;
		int           k;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		it = raw[$bits(in_item_t)-1:0];
		k = $urandom_range(0, 99);
		if (k < 25) begin
			it.op = OP_LOAD;
			if ($urandom_range(0, 7) != 0) begin
				it.pos_x = small_coord();
				it.pos_y = small_coord();
				it.pos_z = small_coord();
			end
		end else if (k < 72) begin
			it.op = OP_PAIR;
			if ($urandom_range(0, 9) == 0)
				it.residue_b = it.residue_a;
			if (cutoff_q != 0 && $urandom_range(0, 3) != 0)
				it.ref_distance = $urandom_range(0, cutoff_q - 1);
		end else begin
			it.op = OP_READ;
			if ($urandom_range(0, 5) != 0) begin
				it.row = 8'($urandom_range(0, DOF - 1));
				it.col = 8'(3*(it.row/3) + $urandom_range(0, 2));
				if ($urandom_range(0, 1))
					it.col = 8'($urandom_range(0, DOF - 1));
			end
		end
		return it;
	endfunction

	task automatic drain();
		do @(posedge clk);
		while (cmd_queue.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_cutoff(logic [31:0] v);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		cutoff_q = v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic queue_random(int n);
		repeat (n) enq_cmd(random_cmd());
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		out_ready   = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		cutoff_q    = CUTOFF_RESET;
		foreach (hess[i])
			hess[i] = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// directed: edges of fields, every op, skip and range cases
		enq_cmd(mk(OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0));
		enq_cmd(mk(OP_LOAD, 1, 0, 65536, 0, 0, 0, 0, 0));
		enq_cmd(mk(OP_LOAD, 2, 0, 0, 32768, -32768, 0, 0, 0));
		enq_cmd(mk(OP_LOAD, 3, 0, 0, 0, 0, 0, 0, 0));
		enq_cmd(mk(OP_LOAD, 63, 0, 32'h7FFFFFFF, 32'h80000000,
			32'h7FFFFFFF, 0, 0, 0));
		enq_cmd(mk(OP_LOAD, 62, 0, -65536, 65536, 65536, 0, 0, 0));
		enq_cmd(mk(OP_PAIR, 0, 1, 0, 0, 0, 49152, 0, 0));
		enq_cmd(mk(OP_PAIR, 1, 2, 0, 0, 0, 0, 0, 0));
		enq_cmd(mk(OP_PAIR, 2, 2, 0, 0, 0, 0, 0, 0));
		enq_cmd(mk(OP_PAIR, 0, 1, 0, 0, 0, 98304, 0, 0));
		enq_cmd(mk(OP_PAIR, 0, 3, 0, 0, 0, 0, 0, 0));
		enq_cmd(mk(OP_PAIR, 0, 62, 0, 0, 0, 98303, 0, 0));
		enq_cmd(mk(OP_PAIR, 63, 62, 0, 0, 0, 0, 0, 0));
		enq_cmd(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
		enq_cmd(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 3));
		enq_cmd(mk(OP_READ, 0, 0, 0, 0, 0, 0, 3, 0));
		enq_cmd(mk(OP_READ, 0, 0, 0, 0, 0, 0, 191, 191));
		enq_cmd(mk(OP_READ, 0, 0, 0, 0, 0, 0, 192, 0));
		enq_cmd(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 255));
		enq_cmd(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
		enq_cmd(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
		drain();

		// widest cutoff: tiny distance with huge reference clamps the strain
		set_cutoff(32'hFFFFFFFF);
		enq_cmd(mk(OP_LOAD, 4, 0, 1, 0, 0, 0, 0, 0));
		repeat (3) enq_cmd(mk(OP_PAIR, 0, 4, 0, 0, 0, 32'hFFFFFFFE, 0, 0));
		enq_cmd(mk(OP_READ, 0, 0, 0, 0, 0, 0, 12, 12));
		enq_cmd(mk(OP_PAIR, 63, 62, 0, 0, 0, 32'hFFFFFFFE, 0, 0));
		for (int r = 0; r < NRES; r++)
			enq_cmd(mk(OP_LOAD, r, 0, small_coord(), small_coord(),
				small_coord(), 0, 0, 0));
		queue_random(90);
		drain();

		// zero cutoff: every valid pair is skipped
		set_cutoff(32'd0);
		queue_random(30);
		drain();

		set_cutoff($urandom_range(40000, 400000));
		queue_random(60);
		// long stall on the result side while commands keep coming
		@(posedge clk);
		hold_req = 1;
		queue_random(40);
		enq_cmd(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
		queue_random(30);
		drain();

		set_cutoff(CUTOFF_RESET);
		quiet = 1;
		queue_random(100);
		drain();
		repeat (40) @(posedge clk);

		$display("covered %0d loads, %0d pairs, %0d reads, %0d clears; %0d results checked",
			n_op[OP_LOAD], n_op[OP_PAIR], n_op[OP_READ], n_op[OP_CLEAR], n_results);
		$display("cutoff settings 0, max, random, reset; %0d skipped, %0d saturated, %0d %0s",
			n_skip, n_sat, n_range, "out of range");
		if (errors == 0 && expected_results.size() == 0)
			$display("network_model_hessian_accumulator regression: pass");
		else
			$display("network_model_hessian_accumulator regression: fail");
		$finish;
	end

endmodule
